// File: design/id3fw_pkg.sv
// Shared types, codes and constants of the ID3v2 frame walker.
package id3fw_pkg;

  localparam logic [7:0] MAGIC_0 = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC_1 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_2 = 8'h33;  // '3'

  localparam logic [3:0] TAG_HDR_LAST   = 4'd9;  // last byte of the 10-byte tag header
  localparam logic [3:0] MAGIC_LEN      = 4'd3;
  localparam logic [3:0] IDX_VERSION    = 4'd3;
  localparam logic [3:0] IDX_TAG_FLAGS  = 4'd5;
  localparam logic [3:0] IDX_SIZE_FIRST = 4'd6;
  localparam logic [7:0] MAX_VERSION    = 8'd4;
  localparam logic [7:0] SMALL_VERSION  = 8'd2;
  localparam logic [7:0] SYNCSAFE_VER   = 8'd4;

  // frame header layout, v2.2 and below vs v2.3/v2.4
  localparam logic [3:0] SMALL_ID_LEN   = 4'd3;
  localparam logic [3:0] LARGE_ID_LEN   = 4'd4;
  localparam logic [3:0] SMALL_SIZE_END = 4'd6;
  localparam logic [3:0] LARGE_SIZE_END = 4'd8;
  localparam logic [3:0] SMALL_HDR_LAST = 4'd5;  // 6-byte frame header
  localparam logic [3:0] LARGE_HDR_LAST = 4'd9;  // 10-byte frame header

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_FRAMEHDR = 5'b00010,
    PH_CONTENT = 5'b00100,
    PH_DRAIN   = 5'b01000,
    PH_IDLE    = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_FRAME       = 3'd0,
    KIND_COMPLETE    = 3'd1,
    KIND_NOTAG       = 3'd2,
    KIND_TRUNCATED   = 3'd3,
    KIND_UNSUPPORTED = 3'd4
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  field_count;
    logic [7:0]  version;
    logic [7:0]  hdr_flags;
    logic [27:0] tag_size;
    logic [27:0] remaining;
    logic [31:0] id_accum;
    logic [31:0] len_accum;
    logic [15:0] flags_accum;
    logic [27:0] skip_count;
    logic [28:0] offset;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] frame_id;
    logic [28:0] data_offset;
    logic [27:0] frame_size;
    logic [15:0] frame_flags;
    logic [7:0]  major_version;
    logic [7:0]  tag_flags;
    logic [27:0] tag_size;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_HEADER,
    field_count: 4'd0,
    version:     8'd0,
    hdr_flags:   8'd0,
    tag_size:    28'd0,
    remaining:   28'd0,
    id_accum:    32'd0,
    len_accum:   32'd0,
    flags_accum: 16'd0,
    skip_count:  28'd0,
    offset:      29'd0
  };

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] val;
    unique case (pos)
      2'd0:    val = MAGIC_0;
      2'd1:    val = MAGIC_1;
      default: val = MAGIC_2;
    endcase
    return val;
  endfunction

endpackage

// File: design/id3fw_step.sv
// Per-byte next-state and result logic of the ID3v2 frame walker.
module id3fw_step (
  input  id3fw_pkg::state_t  state_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_file_i,
  output id3fw_pkg::state_t  state_o,
  output logic               res_valid_o,
  output id3fw_pkg::result_t res_o
);
  import id3fw_pkg::*;

  state_t      n;
  logic        hit;
  kind_e       kind;
  logic [31:0] f_id;
  logic [28:0] f_off;
  logic [27:0] f_size;
  logic [15:0] f_flags;
  logic [27:0] rem_dec;
  logic [27:0] skip_dec;
  logic [3:0]  idx;
  logic        short_fmt;
  logic [3:0]  id_len;
  logic [3:0]  size_end;
  logic [3:0]  hdr_last;
  logic [27:0] sync_acc;
  logic [31:0] plain_acc;
  logic        live;

  assign idx       = state_i.field_count;
  assign short_fmt = (state_i.version <= SMALL_VERSION);
  assign id_len    = short_fmt ? SMALL_ID_LEN : LARGE_ID_LEN;
  assign size_end  = short_fmt ? SMALL_SIZE_END : LARGE_SIZE_END;
  assign hdr_last  = short_fmt ? SMALL_HDR_LAST : LARGE_HDR_LAST;
  assign rem_dec   = (state_i.remaining != 28'd0) ? state_i.remaining - 28'd1
                                                  : state_i.remaining;
  assign skip_dec  = (state_i.skip_count != 28'd0) ? state_i.skip_count - 28'd1
                                                   : state_i.skip_count;
  assign sync_acc  = {state_i.len_accum[20:0], data_byte_i[6:0]};
  assign plain_acc = {state_i.len_accum[23:0], data_byte_i};

  always_comb begin
    n       = state_i;
    hit     = 1'b0;
    kind    = KIND_FRAME;
    f_id    = '0;
    f_off   = '0;
    f_size  = '0;
    f_flags = '0;

    unique case (state_i.phase)
      PH_HEADER: begin
        if (idx < MAGIC_LEN) begin
          if (data_byte_i != magic_byte(idx[1:0])) begin
            hit     = 1'b1;
            kind    = KIND_NOTAG;
            n.phase = PH_IDLE;
          end
        end else if (idx == IDX_VERSION) begin
          n.version = data_byte_i;
        end else if (idx == IDX_TAG_FLAGS) begin
          n.hdr_flags = data_byte_i;
        end else if (idx >= IDX_SIZE_FIRST) begin
          n.len_accum = {4'd0, sync_acc};
        end
        if (n.phase == PH_HEADER) begin
          if (idx >= TAG_HDR_LAST) begin
            n.tag_size  = n.len_accum[27:0];
            n.len_accum = '0;
            if (n.version > MAX_VERSION) begin
              hit     = 1'b1;
              kind    = KIND_UNSUPPORTED;
              n.phase = PH_IDLE;
            end else begin
              n.remaining = n.tag_size;
              if (n.tag_size == 28'd0) begin
                hit     = 1'b1;
                kind    = KIND_COMPLETE;
                n.phase = PH_IDLE;
              end else begin
                n.phase       = PH_FRAMEHDR;
                n.field_count = '0;
                n.id_accum    = '0;
                n.flags_accum = '0;
              end
            end
          end else begin
            n.field_count = idx + 4'd1;
          end
        end
      end

      PH_FRAMEHDR: begin
        n.remaining = rem_dec;
        if (idx == 4'd0 && data_byte_i == 8'd0) begin
          // padding: walk ends here
          if (rem_dec == 28'd0) begin
            hit     = 1'b1;
            kind    = KIND_COMPLETE;
            n.phase = PH_IDLE;
          end else begin
            n.phase = PH_DRAIN;
          end
        end else begin
          if (idx < id_len) begin
            n.id_accum = {state_i.id_accum[23:0], data_byte_i};
          end else if (idx < size_end) begin
            n.len_accum = (state_i.version == SYNCSAFE_VER) ? {4'd0, sync_acc} : plain_acc;
          end else begin
            n.flags_accum = {state_i.flags_accum[7:0], data_byte_i};
          end
          if (idx >= hdr_last) begin
            if (n.len_accum != 32'd0 && n.len_accum <= {4'd0, rem_dec}) begin
              hit          = 1'b1;
              kind         = KIND_FRAME;
              f_id         = n.id_accum;
              f_off        = state_i.offset + 29'd1;
              f_size       = n.len_accum[27:0];
              f_flags      = n.flags_accum;
              n.skip_count = n.len_accum[27:0];
              n.phase      = PH_CONTENT;
            end else if (rem_dec == 28'd0) begin
              hit     = 1'b1;
              kind    = KIND_COMPLETE;
              n.phase = PH_IDLE;
            end else begin
              n.phase = PH_DRAIN;
            end
          end else if (rem_dec == 28'd0) begin
            // frame header runs past the tag end
            hit     = 1'b1;
            kind    = KIND_COMPLETE;
            n.phase = PH_IDLE;
          end else begin
            n.field_count = idx + 4'd1;
          end
        end
      end

      PH_CONTENT: begin
        n.remaining  = rem_dec;
        n.skip_count = skip_dec;
        if (skip_dec == 28'd0) begin
          if (rem_dec == 28'd0) begin
            hit     = 1'b1;
            kind    = KIND_COMPLETE;
            n.phase = PH_IDLE;
          end else begin
            n.phase       = PH_FRAMEHDR;
            n.field_count = '0;
            n.id_accum    = '0;
            n.len_accum   = '0;
            n.flags_accum = '0;
          end
        end
      end

      PH_DRAIN: begin
        n.remaining = rem_dec;
        if (rem_dec == 28'd0) begin
          hit     = 1'b1;
          kind    = KIND_COMPLETE;
          n.phase = PH_IDLE;
        end
      end

      default: begin
        // idle, or a phase code that is not one-hot
      end
    endcase

    live = (n.phase == PH_HEADER) || (n.phase == PH_FRAMEHDR) ||
           (n.phase == PH_CONTENT) || (n.phase == PH_DRAIN);
    if (end_of_file_i && live) begin
      hit     = 1'b1;
      kind    = KIND_TRUNCATED;
      f_id    = '0;
      f_off   = '0;
      f_size  = '0;
      f_flags = '0;
    end

    res_valid_o         = hit;
    res_o.kind          = kind;
    res_o.frame_id      = f_id;
    res_o.data_offset   = f_off;
    res_o.frame_size    = f_size;
    res_o.frame_flags   = f_flags;
    res_o.major_version = n.version;
    res_o.tag_flags     = n.hdr_flags;
    res_o.tag_size      = n.tag_size;

    if (end_of_file_i) begin
      state_o = STATE_RESET;
    end else begin
      state_o = n;
      if (state_i.offset != '1) begin
        state_o.offset = state_i.offset + 29'd1;
      end
    end
  end

endmodule

// File: design/id3v2_frame_walker_core.sv
// Top level of the ID3v2 frame walker: input register, step logic, result register.
//
// Usage:
// - Input channel: one file byte per beat (data_byte_i, end_of_file_i), starting at
//   file offset zero; end_of_file_i marks the last byte, and the next beat starts
//   a new file. A beat is taken on a clock edge with in_valid_i high and
//   in_stall_o low.
// - Output channel: at most one result beat per input byte: a frame descriptor
//   (kind 0) or a file status (tag complete, no tag, truncated, unsupported
//   version). A beat moves when out_valid_o is high and out_stall_i is low.
// - Path: a taken byte is loaded into the input register, then goes through the step
//   logic into the result register, which drives the outputs.
// - Throughput: one byte per cycle while out_stall_i holds no result; the per-byte work
//   is a short compare, shift and decrement between the input and result registers.
// - Stall: a held result freezes the processing stage; the input register then
//   fills and in_stall_o rises, so nothing is dropped. A result beat holds steady
//   while stalled.
// - Reset (rst_ni low, async): parser state returns to the tag-header phase at
//   offset zero and both pipeline registers empty.
module id3v2_frame_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] frame_id_o,
  output logic [28:0] data_offset_o,
  output logic [27:0] frame_size_o,
  output logic [15:0] frame_flags_o,
  output logic [7:0]  major_version_o,
  output logic [7:0]  tag_flags_o,
  output logic [27:0] tag_size_o
);
  import id3fw_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eof_q;

  // parser state and result register
  state_t  state_q;
  state_t  state_d;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    res_hit;

  logic stage_stall;  // result register full and not drained
  logic fire;         // buffered byte goes through the step logic

  assign stage_stall = out_valid_q && out_stall_i;
  assign in_stall_o  = in_valid_q && stage_stall;
  assign fire        = in_valid_q && !stage_stall;

  id3fw_step u_step (
    .state_i       (state_q),
    .data_byte_i   (byte_q),
    .end_of_file_i (eof_q),
    .state_o       (state_d),
    .res_valid_o   (res_hit),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!stage_stall) begin
        out_valid_q <= fire && res_hit;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      eof_q  <= end_of_file_i;
    end
    if (fire && res_hit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign frame_id_o      = res_q.frame_id;
  assign data_offset_o   = res_q.data_offset;
  assign frame_size_o    = res_q.frame_size;
  assign frame_flags_o   = res_q.frame_flags;
  assign major_version_o = res_q.major_version;
  assign tag_flags_o     = res_q.tag_flags;
  assign tag_size_o      = res_q.tag_size;

endmodule
